// ===== hdl/motion_command_frame_parser_top_defines.svh =====
// assertion macros for the motion command frame parser
`ifndef MOTION_COMMAND_FRAME_PARSER_TOP_DEFINES_SVH
`define MOTION_COMMAND_FRAME_PARSER_TOP_DEFINES_SVH

// property that must hold in the same cycle as its antecedent
`define MCFP_ASSERT(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("mcfp assertion failed");

// antecedent in one cycle, consequent in the next
`define MCFP_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mcfp next-cycle assertion failed");

`endif

// ===== hdl/mcfp_pkg.sv =====
// shared types and constants of the motion command frame parser
`default_nettype none

package mcfp_pkg;

	// reset value of the start byte register
	localparam logic [7:0] START_BYTE_RST = 8'hAF;

	// action codes
	localparam logic [1:0] ACT_CAR    = 2'd0;
	localparam logic [1:0] ACT_LIFTER = 2'd1;
	localparam logic [1:0] ACT_CAMERA = 2'd2;

	// frame positions: hunting, then index of the next expected byte
	typedef logic [3:0] mcfp_pos_t;
	localparam mcfp_pos_t POS_HUNT    = 4'd0;
	localparam mcfp_pos_t POS_ACTION  = 4'd1;
	localparam mcfp_pos_t POS_MDIST_H = 4'd2;
	localparam mcfp_pos_t POS_MDIST_L = 4'd3;
	localparam mcfp_pos_t POS_MDIR    = 4'd4;
	localparam mcfp_pos_t POS_RDIST_H = 4'd5;
	localparam mcfp_pos_t POS_RDIST_L = 4'd6;
	localparam mcfp_pos_t POS_RDIR    = 4'd7;
	localparam mcfp_pos_t POS_CSUM    = 4'd8;

	// one decoded command, first field in the highest bits
	typedef struct packed {
		logic [7:0]  rotate_direction;
		logic [15:0] rotate_distance;
		logic [7:0]  move_direction;
		logic [15:0] move_distance;
		logic [1:0]  target;
	} mcfp_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/mcfp_parser.sv =====
// frame state machine: position, running checksum and held fields
`default_nettype none

module mcfp_parser
	import mcfp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       byte_accept,
	input  wire logic [7:0] rx_byte,
	input  wire logic [7:0] start_byte,
	output mcfp_pos_t       frame_pos,
	output logic            cmd_valid,
	output mcfp_cmd_t       cmd
);

	mcfp_pos_t   pos_q;
	logic [7:0]  sum_q;
	logic [1:0]  action_q;
	logic [15:0] mdist_q;
	logic [7:0]  mdir_q;
	logic [15:0] rdist_q;
	logic [7:0]  rdir_q;

	logic        move_ok;
	logic        rot_ok;
	mcfp_pos_t   pos_d;

	// move direction check against the held action
	always_comb begin
		unique case (action_q)
			ACT_CAR:    move_ok = (rx_byte <= 8'd3);
			ACT_LIFTER: move_ok = (rx_byte == 8'd0) || (rx_byte == 8'd2);
			default:    move_ok = 1'b1;
		endcase
	end

	// rotate direction check on its top two bits
	assign rot_ok = (action_q == ACT_LIFTER) ? (rx_byte[7:6] == 2'd0)
		: (rx_byte[7:6] == 2'd3);

	// next frame position
	always_comb begin
		unique case (pos_q)
			POS_HUNT:    pos_d = (rx_byte == start_byte) ? POS_ACTION : POS_HUNT;
			POS_ACTION:  pos_d = (rx_byte <= 8'd2) ? POS_MDIST_H : POS_HUNT;
			POS_MDIST_H: pos_d = POS_MDIST_L;
			POS_MDIST_L: pos_d = POS_MDIR;
			POS_MDIR:    pos_d = move_ok ? POS_RDIST_H : POS_HUNT;
			POS_RDIST_H: pos_d = POS_RDIST_L;
			POS_RDIST_L: pos_d = POS_RDIR;
			POS_RDIR:    pos_d = rot_ok ? POS_CSUM : POS_HUNT;
			default:     pos_d = POS_HUNT;
		endcase
	end

	// state and held fields, updated on every accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= POS_HUNT;
			sum_q    <= '0;
			action_q <= ACT_CAR;
			mdist_q  <= '0;
			mdir_q   <= '0;
			rdist_q  <= '0;
			rdir_q   <= '0;
		end else if (byte_accept) begin
			pos_q <= pos_d;
			if (pos_q == POS_HUNT) begin
				sum_q <= '0;
			end else if (pos_q <= POS_RDIR) begin
				sum_q <= sum_q + rx_byte;
			end
			unique case (pos_q)
				POS_ACTION:  action_q       <= rx_byte[1:0];
				POS_MDIST_H: mdist_q        <= {rx_byte, 8'h00};
				POS_MDIST_L: mdist_q[7:0]   <= rx_byte;
				POS_MDIR:    mdir_q         <= rx_byte;
				POS_RDIST_H: rdist_q        <= {rx_byte, 8'h00};
				POS_RDIST_L: rdist_q[7:0]   <= rx_byte;
				POS_RDIR:    rdir_q         <= rx_byte;
				default: begin
				end
			endcase
		end
	end

	// checksum byte completes the command
	assign cmd_valid = byte_accept && (pos_q == POS_CSUM) && (sum_q == rx_byte);
	assign frame_pos = pos_q;

	assign cmd.target           = action_q;
	assign cmd.move_distance    = mdist_q;
	assign cmd.move_direction   = mdir_q;
	assign cmd.rotate_distance  = rdist_q;
	assign cmd.rotate_direction = rdir_q;

endmodule

`default_nettype wire

// ===== hdl/motion_command_frame_parser_top.sv =====
// Motion command frame parser. Takes one received byte per item on the
// slave stream and hunts for a 9-byte frame: start byte (cfg register,
// reset 0xAF), action, move distance high/low, move direction, rotate
// distance high/low, rotate direction and an 8-bit wrapping sum of bytes
// 2 to 8. Checks on action and directions send it back to hunting; a
// frame with a matching sum yields one command on the master stream. One
// byte is taken every cycle while tready is high, and each updates the frame state.
// The decoded command sits in an output register; bytes keep flowing
// while it waits, and tready drops only while the next byte is the checksum
// and the previous command is still untaken.
`default_nettype none
`include "motion_command_frame_parser_top_defines.svh"

module motion_command_frame_parser_top
	import mcfp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration: start byte
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_wdata,
	// received bytes; tdata: rx_byte[7:0]
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,
	// commands; tdata: target[1:0], move_distance[17:2], move_direction[25:18],
	// rotate_distance[41:26], rotate_direction[49:42], zero[55:50]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [55:0]      m_axis_tdata
);

	logic [7:0] start_byte_q;
	logic       s_accept;
	mcfp_pos_t  frame_pos;
	logic       cmd_valid;
	mcfp_cmd_t  cmd;
	logic       out_valid_q;
	mcfp_cmd_t  out_cmd_q;

	// start byte register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= START_BYTE_RST;
		end else if (cfg_we) begin
			start_byte_q <= cfg_wdata;
		end
	end

	// stall only a checksum byte that could land on a full output
	assign s_axis_tready = !(out_valid_q && !m_axis_tready && (frame_pos == POS_CSUM));
	assign s_accept      = s_axis_tvalid && s_axis_tready;

	mcfp_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_accept(s_accept),
		.rx_byte    (s_axis_tdata),
		.start_byte (start_byte_q),
		.frame_pos  (frame_pos),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid) begin
			out_cmd_q <= cmd;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'b0, out_cmd_q};

	// never overwrite a command that is still waiting
	`MCFP_ASSERT(a_no_overwrite, (out_valid_q && !m_axis_tready) |-> !cmd_valid)
	// a command comes only from the checksum position
	`MCFP_ASSERT(a_cmd_at_csum, cmd_valid |-> (frame_pos == POS_CSUM))
	// the input stalls only on a checksum byte
	`MCFP_ASSERT(a_stall_at_csum, !s_axis_tready |-> (frame_pos == POS_CSUM))
	// after a checksum byte the parser hunts again
	`MCFP_ASSERT_NEXT(a_hunt_after_csum, s_accept && (frame_pos == POS_CSUM),
		frame_pos == POS_HUNT)

endmodule

`default_nettype wire
